// File: src/xte_pkg.sv
// shared types, character codes and run-expansion helpers for the xml text escaper
`default_nettype none

package xte_pkg;

  // run kinds: how one accepted byte expands on the output
  localparam logic [2:0] KIND_PLAIN = 3'd0;
  localparam logic [2:0] KIND_AMP   = 3'd1;
  localparam logic [2:0] KIND_LT    = 3'd2;
  localparam logic [2:0] KIND_GT    = 3'd3;
  localparam logic [2:0] KIND_QUOT  = 3'd4;
  localparam logic [2:0] KIND_HEX   = 3'd5;

  // input characters that need escaping
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3c;
  localparam logic [7:0] CH_GT   = 8'h3e;
  localparam logic [7:0] CH_QUOT = 8'h22;

  // entity texts, left aligned in six byte slots
  localparam logic [47:0] TXT_AMP  = {"&amp;", 8'h00};
  localparam logic [47:0] TXT_LT   = {"&lt;", 16'h0000};
  localparam logic [47:0] TXT_GT   = {"&gt;", 16'h0000};
  localparam logic [47:0] TXT_QUOT = "&quot;";
  localparam logic [23:0] TXT_HEX_HEAD = "&#x";
  localparam logic [7:0]  TXT_SEMI     = ";";

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } xte_entry_t;

  // lower-case hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_digit = wide + 8'h30;
    end else begin
      hex_digit = wide + 8'h57;
    end
  endfunction

  // number of output bytes a run produces
  function automatic logic [2:0] run_len(input logic [2:0] kind);
    unique case (kind)
      KIND_AMP:              run_len = 3'd5;
      KIND_LT, KIND_GT:      run_len = 3'd4;
      KIND_QUOT, KIND_HEX:   run_len = 3'd6;
      default:               run_len = 3'd1;
    endcase
  endfunction

  // byte at position idx of a run
  function automatic logic [7:0] run_byte(input xte_entry_t ent, input logic [2:0] idx);
    logic [47:0] txt;
    unique case (ent.kind)
      KIND_AMP:  txt = TXT_AMP;
      KIND_LT:   txt = TXT_LT;
      KIND_GT:   txt = TXT_GT;
      KIND_QUOT: txt = TXT_QUOT;
      KIND_HEX:  txt = {TXT_HEX_HEAD, hex_digit(ent.data[7:4]), hex_digit(ent.data[3:0]),
                        TXT_SEMI};
      default:   txt = {ent.data, 40'h0};
    endcase
    run_byte = txt[6'd47 - {idx, 3'b000} -: 8];
  endfunction

endpackage

`default_nettype wire

// File: src/xte_in_if.sv
// input channel: one text byte with its escaping mode
`default_nettype none

interface xte_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_byte;

  modport source (output valid, output command, output in_byte, input ready);
  modport sink (input valid, input command, input in_byte, output ready);
endinterface

`default_nettype wire

// File: src/xte_out_if.sv
// output channel: one escaped byte with its end-of-run flag
`default_nettype none

interface xte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: src/xte_front.sv
// front end: accepts text bytes, drops terminators and classifies the rest into runs
`default_nettype none

module xte_front
  import xte_pkg::*;
(
  xte_in_if.sink      in_ch,
  input  wire logic   q_full,
  output logic        push,
  output xte_entry_t  push_ent
);

  logic [2:0] kind;

  always_comb begin
    unique case (in_ch.in_byte)
      CH_AMP:  kind = KIND_AMP;
      CH_LT:   kind = KIND_LT;
      CH_GT:   kind = KIND_GT;
      CH_QUOT: kind = in_ch.command ? KIND_QUOT : KIND_PLAIN;
      default: kind = in_ch.in_byte[7] ? KIND_HEX : KIND_PLAIN;
    endcase
  end

  assign in_ch.ready   = !q_full;
  // terminator is consumed but queues nothing
  assign push          = in_ch.valid && !q_full && (in_ch.in_byte != CH_NUL);
  assign push_ent.kind = kind;
  assign push_ent.data = in_ch.in_byte;

endmodule

`default_nettype wire

// File: src/xte_queue.sv
// two-entry run queue between front and back ends
`default_nettype none

module xte_queue
  import xte_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire xte_entry_t  push_ent,
  input  wire logic        pop,
  output logic             full,
  output logic             head_valid,
  output xte_entry_t       head_ent
);

  xte_entry_t mem [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'(QUEUE_DEPTH));
  assign head_valid = (count != 2'd0);
  assign head_ent   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/xte_back.sv
// back end: walks the head run one byte per cycle, unless stalled, into a registered output
`default_nettype none

module xte_back
  import xte_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  wire xte_entry_t  head_ent,
  output logic             pop,
  xte_out_if.source        out_ch
);

  logic       idx;
  logic [2:0] pos;
  logic       load;
  logic       at_last;
  logic       o_valid;
  logic [7:0] o_byte;
  logic       o_last;

  assign load    = head_valid && (!o_valid || out_ch.ready);
  assign at_last = (pos == run_len(head_ent.kind) - 3'd1);
  assign pop     = load && at_last;
  assign idx     = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      pos     <= 3'd0;
    end else begin
      if (load) begin
        o_valid <= 1'b1;
        pos     <= at_last ? 3'd0 : pos + 3'd1;
      end else if (out_ch.ready) begin
        o_valid <= idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_byte <= run_byte(head_ent, pos);
      o_last <= at_last;
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.out_byte    = o_byte;
  assign out_ch.last_of_run = o_last;

endmodule

`default_nettype wire

// File: src/xml_text_escaper_core.sv
// top level of the xml text escaper: front end, run queue and back end
`default_nettype none

// xml text escaper. Each input item is one text byte plus a mode bit (0 element
// text, 1 attribute value). The block emits the escaped text as a run of output
// items: '&', '<', '>' become &amp; &lt; &gt;, in attribute mode '"' becomes
// &quot;, any byte with bit 7 set becomes &#xhh; with lower-case hex, and all other
// nonzero bytes pass through. last_of_run marks the final byte of each run. A zero
// byte is accepted and produces nothing. Rate: while the output is not stalled,
// the back end emits one output byte per cycle, and an escaped byte expands to a
// run of 4, 5 or 6 bytes; the sustained input rate is one item per cycle for
// plain text with the output not stalled. Input is taken whenever the two-entry
// run queue has room, so the input side keeps flowing, until the queue fills,
// while the output register holds a stalled byte. An accepted item passes the
// queue register, then the output register. No state is kept between items.

module xml_text_escaper_core
  import xte_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  xte_in_if.sink     in_ch,
  xte_out_if.source  out_ch
);

  // front to queue
  logic       push;
  xte_entry_t push_ent;
  logic       q_full;

  // queue to back
  logic       head_valid;
  xte_entry_t head_ent;
  logic       pop;

  // classify and drop terminators
  xte_front u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_ent (push_ent)
  );

  // decouples input acceptance from run expansion
  xte_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ent   (push_ent),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_ent   (head_ent)
  );

  // expand runs byte by byte into the output register
  xte_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_ent   (head_ent),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// File: tb/esc_check_pkg.sv
// escaped-text predictor and result scoreboard for the xml text escaper testbench
`timescale 1ns / 100ps

package esc_check_pkg;
  import xte_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } esc_byte_t;

  class escape_board;
    esc_byte_t   expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // queue one escaped run, flagging its final byte
    function void push_run(string txt);
      esc_byte_t eb;
      for (int i = 0; i < txt.len(); i++) begin
        eb.data = txt[i];
        eb.last = (i == txt.len() - 1);
        expected_q.push_back(eb);
      end
    endfunction

    // an accepted text byte: predict its escaped run
    function void note_input(logic attr, logic [7:0] b);
      if (b == CH_NUL) begin
        return;
      end
      if (b == CH_AMP) begin
        push_run("&amp;");
      end else if (b == CH_LT) begin
        push_run("&lt;");
      end else if (b == CH_GT) begin
        push_run("&gt;");
      end else if (b == CH_QUOT && attr) begin
        push_run("&quot;");
      end else if (b[7]) begin
        push_run($sformatf("&#x%02x;", b));
      end else begin
        push_run(string'(b));
      end
    endfunction

    // an accepted output byte: compare with the oldest prediction
    function void check_result(logic [7:0] got_data, logic got_last);
      esc_byte_t eb;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output item, actual byte %h last %b",
                 $time, got_data, got_last);
        errors++;
        return;
      end
      eb = expected_q.pop_front();
      if (got_data !== eb.data) begin
        $display("%0t: out_byte mismatch, expected %h actual %h", $time, eb.data, got_data);
        errors++;
      end
      if (got_last !== eb.last) begin
        $display("%0t: last_of_run mismatch, expected %b actual %b",
                 $time, eb.last, got_last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// top-level testbench for xml_text_escaper_core
`timescale 1ns / 100ps

module tb_top;
  import xte_pkg::*;
  import esc_check_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 380;
  localparam int unsigned QUIET_TAIL   = 50;     // last items run with no idling
  localparam int unsigned HOLD_CYCLES  = 80;     // long receiver hold-off
  localparam int unsigned HOLD_ITEMS   = 30;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  logic clk = 1'b0;
  logic rst;

  xte_in_if  in_ch();
  xte_out_if out_ch();

  xml_text_escaper_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  escape_board board = new();

  // handshake flags between the sender and the receiver
  bit hold_off_req = 1'b0;
  bit quiet_phase  = 1'b0;

  int unsigned cycle_count = 0;

  // extremes of the byte range and every escaped character, run in both modes
  logic [7:0] corner_bytes [10] = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hff,
                                    8'h26, 8'h3c, 8'h3e, 8'h22, 8'h41};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // output monitor: every accepted item goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      board.check_result(out_ch.out_byte, out_ch.last_of_run);
    end
  end

  // receiver: random stall bursts, calm stretches, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        // the sender keeps offering items meanwhile, so the run queue fills up
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (quiet_phase) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // offer one item and hold it until the block takes it; called at a clock edge
  task automatic send_byte(input logic attr, input logic [7:0] b);
    in_ch.valid   <= 1'b1;
    in_ch.command <= attr;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_input(attr, b);
  endtask

  task automatic sender_gap(input int unsigned n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending until every predicted byte has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // text byte mix: plenty of escapes and high bytes, some terminators as noise
  function automatic logic [7:0] pick_text_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 3))
          0: b = CH_AMP;
          1: b = CH_LT;
          2: b = CH_GT;
          default: b = CH_QUOT;
        endcase
      end
      2, 3: b = 8'($urandom_range(128, 255));
      9:    b = ($urandom_range(0, 1) != 0) ? CH_NUL : 8'($urandom_range(1, 255));
      default: b = 8'($urandom_range(1, 127));
    endcase
    return b;
  endfunction

  // sender: directed corners, long hold-off, then random strings
  initial begin
    int unsigned sent;
    int unsigned str_len;
    logic        attr;
    logic        gappy;
    bit          mid_pause_done;
    logic [7:0]  b;

    mid_pause_done = 1'b0;
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.command <= 1'b0;
    in_ch.in_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: corners of the byte range and every escape, in both modes
    // (the quote passes through in element mode, zero gives no output)
    for (int m = 0; m < 2; m++) begin
      foreach (corner_bytes[i]) begin
        send_byte(m[0], corner_bytes[i]);
        if ($urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 14));
      end
    end
    wait_drained();

    // long receiver hold-off while long runs keep coming
    hold_off_req = 1'b1;
    repeat (HOLD_ITEMS) begin
      b = ($urandom_range(0, 1) != 0) ? pick_text_byte() : 8'($urandom_range(128, 255));
      send_byte(1'($urandom_range(0, 1)), b);
    end
    wait_drained();

    // random strings, each closed by a terminator
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - QUIET_TAIL) quiet_phase = 1'b1;
      if (sent >= RANDOM_ITEMS / 2 && !mid_pause_done) begin
        wait_drained();
        mid_pause_done = 1'b1;
      end
      attr    = 1'($urandom_range(0, 1));
      gappy   = ($urandom_range(0, 2) != 0);
      str_len = $urandom_range(1, 14);
      for (int k = 0; k < str_len; k++) begin
        b = pick_text_byte();
        // now and then the mode flips inside a string
        if ($urandom_range(0, 15) == 0) attr = ~attr;
        send_byte(attr, b);
        sent++;
        if (gappy && !quiet_phase && $urandom_range(0, 3) == 0) begin
          sender_gap($urandom_range(1, 14));
        end
      end
      send_byte(attr, CH_NUL);
      sent++;
    end

    // let the last runs come out, then give stray output a chance to show
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: xml_text_escaper_core.f
src/xte_pkg.sv
src/xte_in_if.sv
src/xte_out_if.sv
src/xte_front.sv
src/xte_queue.sv
src/xte_back.sv
src/xml_text_escaper_core.sv
tb/esc_check_pkg.sv
tb/tb_top.sv
